// ----- src/lc3_pkg.sv -----
// shared types, codes and helpers for the lc3 core
// used by lc3_ctrl, lc3_dp and lc3_instruction_execute; no dependencies
package lc3_pkg;

  localparam int MEM_WORDS_DEF = 65536;
  localparam logic [15:0] PC_RESET = 16'h3000;

  localparam logic [2:0] FLAG_P = 3'd1;
  localparam logic [2:0] FLAG_Z = 3'd2;
  localparam logic [2:0] FLAG_N = 3'd4;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_STEP  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  localparam logic [3:0] OP_BR   = 4'h0;
  localparam logic [3:0] OP_ADD  = 4'h1;
  localparam logic [3:0] OP_LD   = 4'h2;
  localparam logic [3:0] OP_ST   = 4'h3;
  localparam logic [3:0] OP_JSR  = 4'h4;
  localparam logic [3:0] OP_AND  = 4'h5;
  localparam logic [3:0] OP_LDR  = 4'h6;
  localparam logic [3:0] OP_STR  = 4'h7;
  localparam logic [3:0] OP_NOT  = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_STI  = 4'hB;
  localparam logic [3:0] OP_JMP  = 4'hC;
  localparam logic [3:0] OP_LEA  = 4'hE;
  localparam logic [3:0] OP_TRAP = 4'hF;

  localparam logic [7:0] VEC_GETC = 8'h20;
  localparam logic [7:0] VEC_OUT  = 8'h21;
  localparam logic [7:0] VEC_IN   = 8'h23;
  localparam logic [7:0] VEC_HALT = 8'h25;

  localparam logic [2:0] REG_START_PC = 3'd0;

  typedef struct packed {
    logic clear;
    logic take;
    logic load;
    logic start;
    logic fetch;
    logic decode;
    logic opnd;
    logic exec;
    logic ind;
    logic mem_wb;
    logic key_wb;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic       halted;
    logic       out_free;
    logic [3:0] op;
    logic [7:0] trapvec;
  } sts_t;

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    logic [2:0] f;
    if (v == 16'd0) begin
      f = FLAG_Z;
    end else if (v[15]) begin
      f = FLAG_N;
    end else begin
      f = FLAG_P;
    end
    return f;
  endfunction

endpackage

// ----- src/lc3_ifs.sv -----
// valid/ready channel interfaces for the lc3 core input and result items
// no dependencies
interface lc3_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] load_addr;
  logic [15:0] load_data;
  logic [7:0]  key_char;
  modport source(output valid, func, load_addr, load_data, key_char, input ready);
  modport sink(input valid, func, load_addr, load_data, key_char, output ready);
endinterface

interface lc3_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pc_now;
  logic [15:0] instr_done;
  logic        char_valid;
  logic [7:0]  char_out;
  logic        halted;
  logic        fault;
  logic [2:0]  cond_flags;
  modport source(output valid, pc_now, instr_done, char_valid, char_out, halted, fault,
                 cond_flags, input ready);
  modport sink(input valid, pc_now, instr_done, char_valid, char_out, halted, fault,
               cond_flags, output ready);
endinterface

// ----- src/lc3_ram.sv -----
// generic single port ram with registered read
// no dependencies
module lc3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- src/lc3_ctrl.sv -----
// sequencer for the lc3 core: clear pass, fetch, operand reads, execute, write back
// depends on lc3_pkg
module lc3_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_func,
  output logic          in_ready,
  input  lc3_pkg::sts_t sts,
  output lc3_pkg::cmd_t cmd
);
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_FETCH = 4'd2;
  localparam logic [3:0] ST_OPND  = 4'd3;
  localparam logic [3:0] ST_EXEC  = 4'd4;
  localparam logic [3:0] ST_IND   = 4'd5;
  localparam logic [3:0] ST_MEMWB = 4'd6;
  localparam logic [3:0] ST_KEY   = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_FIN;
          case (in_func)
            lc3_pkg::FUNC_LOAD:  cmd.load = 1'b1;
            lc3_pkg::FUNC_START: cmd.start = 1'b1;
            lc3_pkg::FUNC_STEP: begin
              if (!sts.halted) begin
                cmd.fetch = 1'b1;
                state_nxt = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        cmd.decode = 1'b1;
        state_nxt  = ST_OPND;
      end
      ST_OPND: begin
        cmd.opnd  = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.op)
          lc3_pkg::OP_LD, lc3_pkg::OP_LDR: state_nxt = ST_MEMWB;
          lc3_pkg::OP_LDI, lc3_pkg::OP_STI: state_nxt = ST_IND;
          lc3_pkg::OP_TRAP: begin
            if (sts.trapvec inside {lc3_pkg::VEC_GETC, lc3_pkg::VEC_IN}) begin
              state_nxt = ST_KEY;
            end else begin
              state_nxt = ST_FIN;
            end
          end
          default: state_nxt = ST_FIN;
        endcase
      end
      ST_IND: begin
        cmd.ind = 1'b1;
        if (sts.op == lc3_pkg::OP_LDI) begin
          state_nxt = ST_MEMWB;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_MEMWB: begin
        cmd.mem_wb = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_KEY: begin
        cmd.key_wb = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_step_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func == lc3_pkg::FUNC_STEP && !sts.halted)
      |=> state_r == ST_FETCH)
    else $error("step not fetched");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("ready while busy");
  a_clear_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && sts.clear_done) |=> state_r == ST_IDLE)
    else $error("clear pass did not end");
endmodule

// ----- src/lc3_dp.sv -----
// lc3 datapath: pc, flags, instruction and operand registers, word memory,
// register file and result register; depends on lc3_pkg and lc3_ram
module lc3_dp #(
  parameter int MEM_WORDS = lc3_pkg::MEM_WORDS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lc3_pkg::cmd_t cmd,
  output lc3_pkg::sts_t sts,
  input  logic [15:0]   start_pc,
  input  logic [15:0]   load_addr,
  input  logic [15:0]   load_data,
  input  logic [7:0]    key_char,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [15:0]   pc_now,
  output logic [15:0]   instr_done,
  output logic          char_valid,
  output logic [7:0]    char_out,
  output logic          halted,
  output logic          fault,
  output logic [2:0]    cond_flags
);
  localparam int AW = $clog2(MEM_WORDS);

  logic [15:0]   pc_r, pc_nxt, ir_r, a_r, b_r, done_r;
  logic [2:0]    cc_r, cc_nxt;
  logic          halt_r, halt_nxt, fault_r, fault_nxt;
  logic          cv_r, cv_nxt;
  logic [7:0]    co_r, co_nxt, key_r;
  logic [AW-1:0] cnt_r;
  logic          oob_r;

  logic [15:0] mem_addr, mem_wd, mem_rdata, mem_q;
  logic        mem_we, in_range;
  logic [2:0]  rf_addr;
  logic [15:0] rf_wd, rf_rdata;
  logic        rf_we, flag_upd;

  logic [3:0]  op;
  logic [2:0]  dr;
  logic [15:0] off9, off6, off11, bval, ea;

  logic        ov_r;
  logic [15:0] o_pc_r, o_done_r;
  logic        o_cv_r, o_halt_r, o_fault_r;
  logic [7:0]  o_co_r;
  logic [2:0]  o_cc_r;

  assign mem_q = oob_r ? 16'd0 : mem_rdata;
  assign op    = ir_r[15:12];
  assign dr    = ir_r[11:9];
  assign off9  = {{7{ir_r[8]}}, ir_r[8:0]};
  assign off6  = {{10{ir_r[5]}}, ir_r[5:0]};
  assign off11 = {{5{ir_r[10]}}, ir_r[10:0]};
  assign bval  = ir_r[5] ? {{11{ir_r[4]}}, ir_r[4:0]} : rf_rdata;
  assign ea    = (op == lc3_pkg::OP_LDR || op == lc3_pkg::OP_STR) ? a_r + off6 : pc_r + off9;

  always_comb begin
    mem_addr  = pc_r;
    mem_we    = 1'b0;
    mem_wd    = b_r;
    rf_addr   = ir_r[2:0];
    rf_we     = 1'b0;
    rf_wd     = 16'd0;
    flag_upd  = 1'b0;
    pc_nxt    = pc_r;
    cc_nxt    = cc_r;
    halt_nxt  = halt_r;
    fault_nxt = fault_r;
    cv_nxt    = cv_r;
    co_nxt    = co_r;
    if (cmd.take) begin
      cv_nxt = 1'b0;
      co_nxt = 8'd0;
    end
    if (cmd.clear) begin
      mem_addr = 16'(cnt_r);
      mem_we   = 1'b1;
      mem_wd   = 16'd0;
      rf_addr  = cnt_r[2:0];
      rf_we    = 1'b1;
    end
    if (cmd.load) begin
      mem_addr = load_addr;
      mem_we   = 1'b1;
      mem_wd   = load_data;
    end
    if (cmd.start) begin
      pc_nxt    = start_pc;
      cc_nxt    = lc3_pkg::FLAG_Z;
      halt_nxt  = 1'b0;
      fault_nxt = 1'b0;
    end
    if (cmd.fetch) begin
      mem_addr = pc_r;
    end
    if (cmd.decode) begin
      pc_nxt  = pc_r + 16'd1;
      rf_addr = (mem_q[15:12] == lc3_pkg::OP_TRAP) ? 3'd0 : mem_q[8:6];
    end
    if (cmd.opnd) begin
      if (op inside {lc3_pkg::OP_ST, lc3_pkg::OP_STR, lc3_pkg::OP_STI}) begin
        rf_addr = dr;
      end else begin
        rf_addr = ir_r[2:0];
      end
    end
    if (cmd.exec) begin
      rf_addr = dr;
      case (op)
        lc3_pkg::OP_BR: begin
          if ((dr & cc_r) != 3'd0) begin
            pc_nxt = pc_r + off9;
          end
        end
        lc3_pkg::OP_ADD: begin
          rf_we = 1'b1; flag_upd = 1'b1; rf_wd = a_r + bval;
        end
        lc3_pkg::OP_AND: begin
          rf_we = 1'b1; flag_upd = 1'b1; rf_wd = a_r & bval;
        end
        lc3_pkg::OP_NOT: begin
          rf_we = 1'b1; flag_upd = 1'b1; rf_wd = ~a_r;
        end
        lc3_pkg::OP_LEA: begin
          rf_we = 1'b1; flag_upd = 1'b1; rf_wd = pc_r + off9;
        end
        lc3_pkg::OP_LD, lc3_pkg::OP_LDR, lc3_pkg::OP_LDI, lc3_pkg::OP_STI: begin
          mem_addr = ea;
        end
        lc3_pkg::OP_ST, lc3_pkg::OP_STR: begin
          mem_addr = ea; mem_we = 1'b1; mem_wd = rf_rdata;
        end
        lc3_pkg::OP_JSR: begin
          pc_nxt  = ir_r[11] ? pc_r + off11 : a_r;
          rf_addr = 3'd7; rf_we = 1'b1; rf_wd = pc_r;
        end
        lc3_pkg::OP_JMP: pc_nxt = a_r;
        lc3_pkg::OP_TRAP: begin
          rf_addr = 3'd7; rf_we = 1'b1; rf_wd = pc_r;
          if (ir_r[7:0] == lc3_pkg::VEC_OUT) begin
            cv_nxt = 1'b1; co_nxt = a_r[7:0];
          end
          if (ir_r[7:0] == lc3_pkg::VEC_HALT) begin
            halt_nxt = 1'b1;
          end
        end
        default: begin
          halt_nxt = 1'b1; fault_nxt = 1'b1;
        end
      endcase
    end
    if (cmd.ind) begin
      mem_addr = mem_q;
      mem_we   = (op == lc3_pkg::OP_STI);
    end
    if (cmd.mem_wb) begin
      rf_addr = dr; rf_we = 1'b1; flag_upd = 1'b1; rf_wd = mem_q;
    end
    if (cmd.key_wb) begin
      rf_addr = 3'd0; rf_we = 1'b1; flag_upd = 1'b1; rf_wd = {8'd0, key_r};
      if (ir_r[7:0] == lc3_pkg::VEC_IN) begin
        cv_nxt = 1'b1; co_nxt = key_r;
      end
    end
    if (flag_upd) begin
      cc_nxt = lc3_pkg::flags_of(rf_wd);
    end
  end

  assign in_range = {1'b0, mem_addr} < 17'(MEM_WORDS);

  lc3_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
    .clk(clk), .we(mem_we && in_range), .addr(mem_addr[AW-1:0]),
    .wdata(mem_wd), .rdata(mem_rdata)
  );

  lc3_ram #(.WIDTH(16), .DEPTH(8)) u_rf (
    .clk(clk), .we(rf_we), .addr(rf_addr), .wdata(rf_wd), .rdata(rf_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= lc3_pkg::PC_RESET;
      cc_r    <= lc3_pkg::FLAG_Z;
      halt_r  <= 1'b0;
      fault_r <= 1'b0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      pc_r    <= pc_nxt;
      cc_r    <= cc_nxt;
      halt_r  <= halt_nxt;
      fault_r <= fault_nxt;
      if (cmd.clear) begin
        cnt_r <= cnt_r + AW'(1);
      end
      if (cmd.publish) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    oob_r <= !in_range;
    cv_r  <= cv_nxt;
    co_r  <= co_nxt;
    if (cmd.take) begin
      key_r  <= key_char;
      done_r <= 16'd0;
    end
    if (cmd.decode) begin
      ir_r   <= mem_q;
      done_r <= mem_q;
    end
    if (cmd.opnd) begin
      a_r <= rf_rdata;
    end
    if (cmd.exec) begin
      b_r <= rf_rdata;
    end
    if (cmd.publish) begin
      o_pc_r    <= pc_r;
      o_done_r  <= done_r;
      o_cv_r    <= cv_r;
      o_co_r    <= co_r;
      o_halt_r  <= halt_r;
      o_fault_r <= fault_r;
      o_cc_r    <= cc_r;
    end
  end

  assign sts.clear_done = (cnt_r == AW'(MEM_WORDS - 1));
  assign sts.halted     = halt_r;
  assign sts.out_free   = !ov_r || out_ready;
  assign sts.op         = op;
  assign sts.trapvec    = ir_r[7:0];

  assign out_valid  = ov_r;
  assign pc_now     = o_pc_r;
  assign instr_done = o_done_r;
  assign char_valid = o_cv_r;
  assign char_out   = o_co_r;
  assign halted     = o_halt_r;
  assign fault      = o_fault_r;
  assign cond_flags = o_cc_r;

  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(cc_r))
    else $error("flags not one-hot");
  a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n) fault_r |-> halt_r)
    else $error("fault without halt");
  a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_valid)
    else $error("result not shown");
endmodule

// ----- src/lc3_instruction_execute.sv -----
// LC-3 core with private word memory, eight registers, pc and n/z/p flags. After reset
// the core first zeroes its memory and register file, one word per cycle, and takes no
// item meanwhile (start_pc writes are still taken). A load or start item then goes to the
// finish state. A step runs fetch, operand, execute and finish; LD, LDR, STI, GETC and IN
// add a memory or key state, LDI the indirect and memory write back states: the single
// port word memory and single port register file are read one address per cycle. A
// result waiting in the output register does not stop the next item from being taken.
// depends on lc3_pkg, lc3_ifs, lc3_ctrl and lc3_dp
module lc3_instruction_execute #(
  parameter int MEM_WORDS = lc3_pkg::MEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lc3_in_if.sink      in_ch,
  lc3_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [2:0] REG_ADDR = {lc3_pkg::REG_START_PC[0], 2'b00};

  lc3_pkg::cmd_t cmd;
  lc3_pkg::sts_t sts;
  logic [15:0]   start_pc_r;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_ADDR) ? {16'd0, start_pc_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pc_r <= lc3_pkg::PC_RESET;
    end else if (psel && penable && pwrite && paddr == REG_ADDR) begin
      start_pc_r <= pwdata[15:0];
    end
  end

  lc3_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_func(in_ch.func),
    .in_ready(in_ch.ready), .sts(sts), .cmd(cmd)
  );

  lc3_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .start_pc(start_pc_r),
    .load_addr(in_ch.load_addr), .load_data(in_ch.load_data), .key_char(in_ch.key_char),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid), .pc_now(out_ch.pc_now),
    .instr_done(out_ch.instr_done), .char_valid(out_ch.char_valid),
    .char_out(out_ch.char_out), .halted(out_ch.halted), .fault(out_ch.fault),
    .cond_flags(out_ch.cond_flags)
  );
endmodule
